### hw/rtl/serial_frame_receiver_top_macros.svh
// ---------------------------------------------------------------------------
// serial frame receiver assertion macros
// concurrent checks that fall away when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define SFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfr check failed");

// consequent must hold in the cycle after the antecedent
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfr check failed");

`else

`define SFR_ASSERT_NOW(label, clk, rst, ante, cons)

`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the serial frame receiver
// ---------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 32;

   // LEN_W length fields cover the whole parameter range (up to 64)
   localparam int LEN_W      = 7;
   localparam int IDX_W      = 6;
   localparam int NUM_BANKS  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int TIMER_W    = 16;

   localparam logic [7:0]         CSUM_SEED         = 8'h55;
   localparam logic [TIMER_W-1:0] IDLE_TIMEOUT_RST  = 16'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SECOND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOOTER_FIRST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOOTER_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT  = 3'd4;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_opcode;
      logic [7:0] frame_subcode;
      logic [5:0] frame_length;
      logic       has_data;
      logic [7:0] data_byte;
      logic [4:0] byte_index;
      logic       last;
   } rsp_type;

   // one accepted frame waiting for emission
   typedef struct packed {
      logic [7:0]       opcode;
      logic [7:0]       subcode;
      logic [LEN_W-1:0] length;
      logic             bank;
   } desc_type;

   // payload buffer write from the parser
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [IDX_W-1:0] index;
      logic [7:0]       data;
   } wr_type;

   typedef enum logic [8:0] {
      PH_HDR1 = 9'b000000001,
      PH_HDR2 = 9'b000000010,
      PH_OPC  = 9'b000000100,
      PH_SUB  = 9'b000001000,
      PH_LEN  = 9'b000010000,
      PH_DATA = 9'b000100000,
      PH_CSUM = 9'b001000000,
      PH_FTR1 = 9'b010000000,
      PH_FTR2 = 9'b100000000
   } phase_type;

   typedef enum logic [2:0] {
      EM_IDLE = 3'b001,
      EM_READ = 3'b010,
      EM_LOAD = 3'b100
   } emit_state_type;

endpackage

`default_nettype wire

### hw/rtl/sfr_queue.sv
// ---------------------------------------------------------------------------
// sfr_queue
// two-entry queue of accepted frame descriptors, one per payload bank
// ---------------------------------------------------------------------------
`default_nettype none

`include "serial_frame_receiver_top_macros.svh"

module sfr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sfr_pkg::desc_type push_desc,
   input  wire logic              pop,
   output logic                   head_valid,
   output sfr_pkg::desc_type      head_desc,
   output logic                   full
);

   localparam int PTR_W = $clog2(sfr_pkg::NUM_BANKS);
   localparam int CNT_W = $clog2(sfr_pkg::NUM_BANKS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(sfr_pkg::NUM_BANKS);

   sfr_pkg::desc_type entry_ff [sfr_pkg::NUM_BANKS];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == FULL_COUNT);

   `SFR_ASSERT_NOW(a_no_push_when_full, clock, reset, count_ff == FULL_COUNT, !push)
   `SFR_ASSERT_NOW(a_no_pop_when_empty, clock, reset, count_ff == '0, !pop)

endmodule

`default_nettype wire

### hw/rtl/sfr_front.sv
// ---------------------------------------------------------------------------
// sfr_front
// frame parser: silence timer, header/length/checksum/footer checks,
// payload writes and descriptor push on a good footer
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_front #(
   parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_take,
   input  wire sfr_pkg::req_type                 req_data,
   input  wire logic                             csr_write,
   input  wire logic [sfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0]   csr_data,
   output sfr_pkg::wr_type                       wr,
   output logic                                  push,
   output sfr_pkg::desc_type                     push_desc
);

   localparam int LW = sfr_pkg::LEN_W;
   localparam int TW = sfr_pkg::TIMER_W;

   // configuration
   logic [7:0]    header_first_ff, header_second_ff;
   logic [7:0]    footer_first_ff, footer_second_ff;
   logic [TW-1:0] idle_timeout_ff;

   sfr_pkg::phase_type phase_ff, phase_in, phase_eff;
   logic [TW-1:0]      silence_ff, silence_in;
   logic               bank_ff, bank_in;
   logic [7:0]         opcode_ff, opcode_in;
   logic [7:0]         subcode_ff, subcode_in;
   logic [LW-1:0]      length_ff, length_in;
   logic [LW-1:0]      fill_ff, fill_in;
   logic [7:0]         csum_ff, csum_in;

   logic          byte_take, tick_take;
   logic [7:0]    rx;
   logic [LW-1:0] fill_next;

   assign rx        = req_data.rx_byte;
   assign byte_take = req_take && (req_data.operation == sfr_pkg::OP_BYTE);
   assign tick_take = req_take && (req_data.operation == sfr_pkg::OP_TICK);
   assign fill_next = fill_ff + LW'(1);

   // a byte after too much silence is parsed as a first header byte
   assign phase_eff = (silence_ff >= idle_timeout_ff) ? sfr_pkg::PH_HDR1 : phase_ff;

   always_comb begin
      phase_in   = phase_ff;
      silence_in = silence_ff;
      bank_in    = bank_ff;
      opcode_in  = opcode_ff;
      subcode_in = subcode_ff;
      length_in  = length_ff;
      fill_in    = fill_ff;
      csum_in    = csum_ff;
      wr.en      = 1'b0;
      wr.bank    = bank_ff;
      wr.index   = sfr_pkg::IDX_W'(fill_ff);
      wr.data    = rx;
      push       = 1'b0;
      push_desc.opcode  = opcode_ff;
      push_desc.subcode = subcode_ff;
      push_desc.length  = length_ff;
      push_desc.bank    = bank_ff;

      if (tick_take) begin
         if (silence_ff != '1) begin
            silence_in = silence_ff + TW'(1);
         end
      end else if (byte_take) begin
         silence_in = '0;
         case (phase_eff)
            sfr_pkg::PH_HDR2: begin
               phase_in = (rx == header_second_ff) ? sfr_pkg::PH_OPC : sfr_pkg::PH_HDR1;
            end
            sfr_pkg::PH_OPC: begin
               opcode_in = rx;
               csum_in   = sfr_pkg::CSUM_SEED ^ rx;
               phase_in  = sfr_pkg::PH_SUB;
            end
            sfr_pkg::PH_SUB: begin
               subcode_in = rx;
               csum_in    = csum_ff ^ rx;
               phase_in   = sfr_pkg::PH_LEN;
            end
            sfr_pkg::PH_LEN: begin
               if (rx > 8'(MAX_PAYLOAD)) begin
                  phase_in = sfr_pkg::PH_HDR1;
               end else begin
                  length_in = LW'(rx);
                  fill_in   = '0;
                  csum_in   = csum_ff ^ rx;
                  phase_in  = (rx != 8'd0) ? sfr_pkg::PH_DATA : sfr_pkg::PH_CSUM;
               end
            end
            sfr_pkg::PH_DATA: begin
               wr.en   = 1'b1;
               csum_in = csum_ff ^ rx;
               fill_in = fill_next;
               if (fill_next >= length_ff) begin
                  phase_in = sfr_pkg::PH_CSUM;
               end
            end
            sfr_pkg::PH_CSUM: begin
               phase_in = (rx == csum_ff) ? sfr_pkg::PH_FTR1 : sfr_pkg::PH_HDR1;
            end
            sfr_pkg::PH_FTR1: begin
               phase_in = (rx == footer_first_ff) ? sfr_pkg::PH_FTR2 : sfr_pkg::PH_HDR1;
            end
            sfr_pkg::PH_FTR2: begin
               phase_in = sfr_pkg::PH_HDR1;
               if (rx == footer_second_ff) begin
                  push    = 1'b1;
                  bank_in = ~bank_ff;
               end
            end
            default: begin
               phase_in = (rx == header_first_ff) ? sfr_pkg::PH_HDR2 : sfr_pkg::PH_HDR1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= sfr_pkg::PH_HDR1;
         silence_ff       <= '0;
         bank_ff          <= 1'b0;
         header_first_ff  <= '0;
         header_second_ff <= '0;
         footer_first_ff  <= '0;
         footer_second_ff <= '0;
         idle_timeout_ff  <= sfr_pkg::IDLE_TIMEOUT_RST;
      end else begin
         phase_ff   <= phase_in;
         silence_ff <= silence_in;
         bank_ff    <= bank_in;
         if (csr_write) begin
            case (csr_index)
               sfr_pkg::CSR_HEADER_FIRST:  header_first_ff  <= csr_data[7:0];
               sfr_pkg::CSR_HEADER_SECOND: header_second_ff <= csr_data[7:0];
               sfr_pkg::CSR_FOOTER_FIRST:  footer_first_ff  <= csr_data[7:0];
               sfr_pkg::CSR_FOOTER_SECOND: footer_second_ff <= csr_data[7:0];
               sfr_pkg::CSR_IDLE_TIMEOUT:  idle_timeout_ff  <= csr_data[TW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff  <= opcode_in;
      subcode_ff <= subcode_in;
      length_ff  <= length_in;
      fill_ff    <= fill_in;
      csum_ff    <= csum_in;
   end

endmodule

`default_nettype wire

### hw/rtl/sfr_back.sv
// ---------------------------------------------------------------------------
// sfr_back
// payload buffer (two banks) and the emitter that turns a queued frame
// into its run of results
// ---------------------------------------------------------------------------
`default_nettype none

`include "serial_frame_receiver_top_macros.svh"

module sfr_back #(
   parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sfr_pkg::wr_type     wr,
   input  wire logic                head_valid,
   input  wire sfr_pkg::desc_type   head_desc,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output sfr_pkg::rsp_type         rsp_data
);

   localparam int LW        = sfr_pkg::LEN_W;
   localparam int IW        = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int MEM_DEPTH = sfr_pkg::NUM_BANKS * (1 << IW);

   logic [7:0] mem [MEM_DEPTH];
   logic [7:0] rd_data_ff;

   sfr_pkg::emit_state_type state_ff, state_in;
   logic [IW-1:0]           pos_ff, pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sfr_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic          empty_frame;
   logic          is_last;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{wr.bank, wr.index[IW-1:0]}] <= wr.data;
      end
      rd_data_ff <= mem[{head_desc.bank, pos_ff}];
   end

   assign empty_frame = (head_desc.length == '0);
   assign is_last     = empty_frame || ((LW'(pos_ff) + LW'(1)) == head_desc.length);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         sfr_pkg::EM_IDLE: begin
            if (head_valid) begin
               pos_in   = '0;
               state_in = sfr_pkg::EM_READ;
            end
         end
         sfr_pkg::EM_READ: begin
            state_in = sfr_pkg::EM_LOAD;
         end
         sfr_pkg::EM_LOAD: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.frame_opcode   = head_desc.opcode;
               rsp_data_in.frame_subcode  = head_desc.subcode;
               rsp_data_in.frame_length   = 6'(head_desc.length);
               rsp_data_in.has_data       = !empty_frame;
               rsp_data_in.data_byte      = empty_frame ? 8'd0 : rd_data_ff;
               rsp_data_in.byte_index     = 5'(pos_ff);
               rsp_data_in.last           = is_last;
               if (is_last) begin
                  pop      = 1'b1;
                  state_in = sfr_pkg::EM_IDLE;
               end else begin
                  pos_in   = pos_ff + IW'(1);
                  state_in = sfr_pkg::EM_READ;
               end
            end
         end
         default: begin
            state_in = sfr_pkg::EM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfr_pkg::EM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SFR_ASSERT_NOW(a_busy_has_frame, clock, reset, state_ff != sfr_pkg::EM_IDLE, head_valid)
   `SFR_ASSERT_NEXT(a_pop_returns_idle, clock, reset, pop, state_ff == sfr_pkg::EM_IDLE)

endmodule

`default_nettype wire

### hw/rtl/serial_frame_receiver_top.sv
// ---------------------------------------------------------------------------
// serial_frame_receiver_top
// framed serial packet receiver with xor checksum and idle timeout
// ---------------------------------------------------------------------------
// The parser takes one transaction (a received byte or a millisecond tick)
// per cycle while req_stall is low, checks header, length, checksum and
// footer, and captures opcode, subcode and data; a good frame lands in one
// of two payload banks and its descriptor enters a two-entry queue. The
// emitter drains the queue: it picks up each descriptor in EM_IDLE, then for
// each result reads the payload memory in EM_READ and loads the output
// register in EM_LOAD, waiting there while rsp_stall holds the output; a
// frame of n data bytes gives max(n,1) results. req_stall rises only while
// both banks hold frames not yet fully emitted. No clearing pass follows
// reset: only payload written by the current frame is ever read.
// csr_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

`include "serial_frame_receiver_top_macros.svh"

module serial_frame_receiver_top #(
   parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   // input transactions: bytes and ticks
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire sfr_pkg::req_type                req_data,

   // result transactions
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output sfr_pkg::rsp_type                     rsp_data,

   // register writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [sfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0]  csr_data
);

   sfr_pkg::wr_type   wr;
   sfr_pkg::desc_type push_desc;
   sfr_pkg::desc_type head_desc;
   logic              push;
   logic              pop;
   logic              head_valid;
   logic              q_full;
   logic              req_take;

   // both banks owned by pending frames: hold off the parser
   assign req_stall = q_full;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   sfr_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_take  (req_take),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .wr        (wr),
      .push      (push),
      .push_desc (push_desc)
   );

   // frames waiting for (or in) emission, one per bank
   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .full       (q_full)
   );

   sfr_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // the parser never writes the bank that the emitter may be reading
   `SFR_ASSERT_NOW(a_bank_disjoint, clock, reset, wr.en && head_valid, wr.bank != head_desc.bank)

endmodule

`default_nettype wire
